/* rtl/core/swms_pkg.sv */
// Shared types and constants for the sliding-window mode filter.
// No dependencies; imported by swms_front, swms_back and the top level.
`default_nettype none
package swms_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int WIN_IDX_W   = $clog2(MAX_WINDOW);
    localparam int WIN_SIZE_W  = 6;
    localparam int SAMPLE_W    = 8;
    localparam int TOTAL_W     = 32;
    localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RESET = 6'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } t_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mode;
        logic [TOTAL_W-1:0]  total;
    } t_result;

    typedef struct packed {
        logic take;
        logic push;
        logic busy;
    } t_back_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } t_back_state;

endpackage
`default_nettype wire

/* rtl/core/swms_front.sv */
// Front end: two-entry input queue that accepts samples and hands them to the back end.
// Depends on swms_pkg.
`default_nettype none
module swms_front
    import swms_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_take
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/swms_back.sv */
// Back end: window delay line, mode search over the window, running sum and result queue.
// Depends on swms_pkg.
`default_nettype none
module swms_back
    import swms_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clear,
    input  wire logic [WIN_SIZE_W-1:0] i_window,
    input  wire logic                  i_item_valid,
    input  wire t_item                 i_item,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output t_result                    o_result,
    output t_back_status               o_status
);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [SAMPLE_W-1:0]   r_line [MAX_WINDOW];
    logic [WIN_SIZE_W-1:0] r_fill;
    logic [TOTAL_W-1:0]    r_sum;
    logic [WIN_IDX_W-1:0]  r_j;
    logic [WIN_SIZE_W-1:0] r_best_cnt;
    logic [SAMPLE_W-1:0]   r_best_val;
    t_result               r_q [2];
    logic                  r_qw;
    logic                  r_qr;
    logic [1:0]            r_qcnt;

    logic                  w_take;
    logic                  w_push;
    logic                  w_pop;
    logic [WIN_SIZE_W-1:0] w_fill_base;
    logic [WIN_SIZE_W-1:0] w_fill_next;
    logic [MAX_WINDOW-1:0] w_match;
    logic [SAMPLE_W-1:0]   w_cand;
    logic [WIN_SIZE_W-1:0] w_cnt;
    logic                  w_better;
    logic                  w_last;
    logic [TOTAL_W-1:0]    w_sum_new;

    assign w_take      = (r_state == ST_IDLE) && i_item_valid;
    assign w_push      = (r_state == ST_EMIT) && (r_qcnt != 2'd2);
    assign w_pop       = i_pop && !o_empty;
    assign w_fill_base = i_item.restart ? '0 : r_fill;
    assign w_fill_next = (w_fill_base >= i_window) ? w_fill_base : w_fill_base + 1'b1;
    assign w_cand      = r_line[r_j];
    assign w_last      = (r_j == WIN_IDX_W'(i_window - 1'b1));
    assign w_sum_new   = r_sum + TOTAL_W'(r_best_val);

    // count how often the candidate occurs inside the active window
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_match[k] = (WIN_SIZE_W'(k) < i_window) && (r_line[k] == w_cand);
        end
    end
    assign w_cnt    = WIN_SIZE_W'($countones(w_match));
    assign w_better = (w_cnt > r_best_cnt) || ((w_cnt == r_best_cnt) && (w_cand < r_best_val));

    assign o_empty  = (r_qcnt == 2'd0);
    assign o_result = r_q[r_qr];
    assign o_status = '{take: w_take, push: w_push, busy: (r_state != ST_IDLE)};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && (w_fill_next >= i_window)) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else if (w_take) begin
            r_fill <= w_fill_next;
            if (i_item.restart) begin
                r_sum <= '0;
            end
        end else if (w_push) begin
            r_sum <= w_sum_new;
        end
    end

    // advance the delay line and run the search
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_line[0] <= i_item.sample;
            for (int k = 1; k < MAX_WINDOW; k++) begin
                r_line[k] <= r_line[k-1];
            end
            r_j        <= '0;
            r_best_cnt <= '0;
            r_best_val <= '0;
        end else if (r_state == ST_SEARCH) begin
            r_j <= r_j + 1'b1;
            if (w_better) begin
                r_best_cnt <= w_cnt;
                r_best_val <= w_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw   <= 1'b0;
            r_qr   <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_qw <= !r_qw;
            end
            if (w_pop) begin
                r_qr <= !r_qr;
            end
            r_qcnt <= r_qcnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_qw] <= '{mode: r_best_val, total: w_sum_new};
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sliding_window_mode_sum.sv */
// Top level of the sliding-window mode filter: config register, front queue, back end.
// Depends on swms_pkg, swms_front and swms_back.
`default_nettype none
// Sliding-window mode filter. Samples enter through a queue-style port (push/full) and
// results leave through another (empty/pop). Each sample shifts into a window of the last
// window_size samples (0 acts as 1, above 32 acts as 32); once the window is full, each
// sample yields the smallest most frequent value in the window and the running sum of
// all modes since restart, modulo 2^32. Until the window fills, a sample yields nothing.
// The restart flag clears the window fill and the sum before its sample is taken; a
// config write does the same and sets the new window size, and must be issued only while
// the block is idle. In the back end, a sample that does not fill the window is taken in
// the idle state only; one that yields a result then runs the mode search, which visits
// one window position per cycle and counts that value across the whole window with a
// compare-and-popcount unit, then waits in the emit state for room in the result queue.
// Two-entry input and result queues decouple the back end from both neighbors.
module sliding_window_mode_sum
    import swms_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    input  wire logic                  i_restart,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [SAMPLE_W-1:0]        o_window_mode,
    output logic [TOTAL_W-1:0]         o_mode_total,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [WIN_SIZE_W-1:0] i_cfg_window_size
);

    logic [WIN_SIZE_W-1:0] r_window_size;
    logic [WIN_SIZE_W-1:0] w_window;
    logic                  w_cfg_wr;
    logic                  w_item_valid;
    t_item                 w_item;
    t_result               w_result;
    t_back_status          w_status;

    // config is always taken; the caller only writes while idle
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WIN_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_window_size <= i_cfg_window_size;
        end
    end

    // clamp the window to 1..MAX_WINDOW
    always_comb begin
        priority if (r_window_size == '0) begin
            w_window = WIN_SIZE_W'(1);
        end else if (r_window_size > WIN_SIZE_W'(MAX_WINDOW)) begin
            w_window = WIN_SIZE_W'(MAX_WINDOW);
        end else begin
            w_window = r_window_size;
        end
    end

    swms_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  ('{sample: i_sample, restart: i_restart}),
        .o_full  (full),
        .o_valid (w_item_valid),
        .o_item  (w_item),
        .i_take  (w_status.take)
    );

    swms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_cfg_wr),
        .i_window     (w_window),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (w_result),
        .o_status     (w_status)
    );

    assign o_window_mode = w_result.mode;
    assign o_mode_total  = w_result.total;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
    a_take_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.take |=> !full)
        else $error("input queue full right after back end took a sample");
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.push |=> !empty)
        else $error("result pushed but queue reads empty");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.take |-> !w_status.busy)
        else $error("sample taken while back end busy");
`endif

endmodule
`default_nettype wire
